### hdl/ctc_gd_pkg.sv
package ctc_gd_pkg;

  // Fixed field widths of the stream and register interfaces.
  localparam int SCORE_W = 18;
  localparam int IDX_W   = 13;
  localparam int CONF_W  = 17;
  localparam int CC_W    = 14;
  localparam int DS_W    = 13;

  // 1.0 in Q1.16 / Q0.16.
  localparam int SCORE_ONE = 65536;

  // Register reset values.
  localparam logic [CC_W-1:0] CLASS_COUNT_RESET = 14'd8192;
  localparam logic [DS_W-1:0] DICT_LEN_RESET    = 13'd8191;

  // Register index codes (address bit 2).
  localparam logic REG_CLASS_COUNT = 1'b0;
  localparam logic REG_DICT_LEN    = 1'b1;

  // Result kinds.
  localparam logic KIND_LABEL = 1'b0;
  localparam logic KIND_CONF  = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_PUSH
  } ctrl_state_t;

  typedef struct packed {
    logic step;
    logic push_conf;
  } ctc_gd_cmd_t;

  typedef struct packed {
    logic fifo_free;
    logic seq_end;
    logic div_busy;
  } ctc_gd_status_t;

  typedef struct packed {
    logic              last;
    logic [CONF_W-1:0] confidence;
    logic [IDX_W-1:0]  dict_index;
    logic              kind;
  } ctc_gd_result_t;

endpackage

### hdl/ctc_greedy_decoder_unit.sv
// CTC greedy (best path) decoder.
// Class scores stream in on the in_ channel, one per transfer, timestep by
// timestep, class_count scores per timestep, class 0 being the blank.
// in_tlast marks the scores of the final timestep of a sequence.
// Results leave on the out_ channel: out_tuser 0 carries a dictionary index
// (argmax class minus one), out_tuser 1 the mean clamped score of the
// emitted labels, which closes the sequence with out_tlast high.
// A label appears on out_ the cycle after the final score of its timestep
// if no earlier result waits. Scores are taken at one per cycle while the
// queue has room and no mean is being computed. At the end of a sequence
// the mean is computed by a bit-serial restoring divider, one quotient bit
// per cycle, over $clog2(MAX_STEPS+1)+19 bits (30 at the defaults); input is
// held until the mean has been queued, before the next sequence starts.
// A two-entry result queue sits in front of out_, so scores keep flowing
// while a result waits; when the receiver stalls and the queue is full,
// in_tready drops until a transfer on out_ frees a slot.
// Reset clears the sequence state and the queue and sets class_count to
// 8192 and the dictionary size to 8191. Registers are written over the
// APB-style cfg_ port: class_count at address 0, dictionary size at 4.
module ctc_greedy_decoder_unit #(
  parameter int MAX_CLASSES = 8192,
  parameter int MAX_STEPS   = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [17:0] score (signed Q1.16), [23:18] zero
  input  logic        in_tlast,    // last_step
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [12:0] dict_index, [29:13] confidence, [31:30] zero
  output logic        out_tuser,   // kind
  output logic        out_tlast,   // last
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import ctc_gd_pkg::*;

  logic [CC_W-1:0] class_count_r, class_count_nxt;
  logic [DS_W-1:0] dict_len_r, dict_len_nxt;
  logic            cfg_wr;

  ctc_gd_cmd_t    cmd;
  ctc_gd_status_t status;
  ctc_gd_result_t result;
  logic           out_valid;

  // The register is chosen by address bit 2; the access completes without
  // wait states since pready is tied high.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    class_count_nxt = class_count_r;
    dict_len_nxt    = dict_len_r;
    if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_CLASS_COUNT: class_count_nxt = cfg_pwdata[CC_W-1:0];
        REG_DICT_LEN:    dict_len_nxt    = cfg_pwdata[DS_W-1:0];
        default: begin
        end
      endcase
    end
    case (cfg_paddr[2])
      REG_CLASS_COUNT: cfg_prdata = 32'(class_count_r);
      REG_DICT_LEN:    cfg_prdata = 32'(dict_len_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r <= CLASS_COUNT_RESET;
      dict_len_r    <= DICT_LEN_RESET;
    end else begin
      class_count_r <= class_count_nxt;
      dict_len_r    <= dict_len_nxt;
    end
  end

  // The controller decides when a score is taken and when the mean is
  // queued; the datapath holds the argmax, repeat memory, sum and queue.
  ctc_gd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ctc_gd_dp #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_STEPS  (MAX_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_score    (in_tdata[SCORE_W-1:0]),
    .in_last_step(in_tlast),
    .class_count (class_count_r),
    .dict_len    (dict_len_r),
    .out_valid   (out_valid),
    .out_pop     (out_valid && out_tready),
    .out_result  (result)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {2'b00, result.confidence, result.dict_index};
  assign out_tuser  = result.kind;
  assign out_tlast  = result.last;

endmodule

### hdl/ctc_gd_div.sv
module ctc_gd_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int IT_W = $clog2(NUM_W + 1);

  logic [IT_W-1:0]  it_r, it_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic             fit;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    fit     = trial >= {1'b0, den_r};
    it_nxt  = it_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    if (start) begin
      it_nxt  = IT_W'(NUM_W);
      rem_nxt = '0;
      quo_nxt = num;
      den_nxt = den;
    end else if (it_r != '0) begin
      it_nxt  = it_r - 1'b1;
      rem_nxt = fit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else begin
      it_r <= it_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy = it_r != '0;
  assign quo  = quo_r;

endmodule

### hdl/ctc_gd_dp.sv
module ctc_gd_dp #(
  parameter int MAX_CLASSES = 8192,
  parameter int MAX_STEPS   = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ctc_gd_pkg::ctc_gd_cmd_t          cmd,
  output ctc_gd_pkg::ctc_gd_status_t       status,
  input  logic [ctc_gd_pkg::SCORE_W-1:0]   in_score,
  input  logic                             in_last_step,
  input  logic [ctc_gd_pkg::CC_W-1:0]      class_count,
  input  logic [ctc_gd_pkg::DS_W-1:0]      dict_len,
  output logic                             out_valid,
  input  logic                             out_pop,
  output ctc_gd_pkg::ctc_gd_result_t       out_result
);

  import ctc_gd_pkg::*;

  localparam int POS_W = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
  localparam int CW    = (POS_W + 1 > CC_W) ? POS_W + 1 : CC_W;
  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam int SUM_W = CONF_W + CNT_W;
  localparam int NUM_W = SUM_W + 2;
  localparam int DEN_W = CNT_W + 1;

  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic [POS_W-1:0]          bclass_r, bclass_nxt;
  logic [POS_W-1:0]          prev_r, prev_nxt;
  logic                      prev_valid_r, prev_valid_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      zero_r, zero_nxt;

  logic signed [SCORE_W-1:0] s;
  logic                      take;
  logic signed [SCORE_W-1:0] b_score;
  logic [POS_W-1:0]          b_class;
  logic [CW-1:0]             cc_ext;
  logic [CW-1:0]             eff;
  logic                      endstep;
  logic                      emit;
  logic                      add;
  logic [CONF_W-1:0]         clamped;
  logic [SUM_W-1:0]          sum_upd;
  logic [CNT_W-1:0]          cnt_upd;
  logic [CW-1:0]             idx_full;
  logic                      push_label;
  logic                      div_start;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic                      div_busy;
  logic [NUM_W-1:0]          div_quo;
  logic [CONF_W-1:0]         conf_val;

  ctc_gd_result_t push_data;
  ctc_gd_result_t slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0]     fcnt_r, fcnt_nxt;
  logic           push;

  always_comb begin
    s       = in_score;
    take    = (pos_r == '0) || (s > best_r);
    b_score = take ? s : best_r;
    b_class = take ? pos_r : bclass_r;

    cc_ext = CW'(class_count);
    if (cc_ext < CW'(2)) begin
      eff = CW'(2);
    end else if (cc_ext > CW'(MAX_CLASSES)) begin
      eff = CW'(MAX_CLASSES);
    end else begin
      eff = cc_ext;
    end
    endstep = (CW'(pos_r) + 1'b1) >= eff;

    emit = (b_class != '0) && (CW'(b_class) <= CW'(dict_len)) &&
           !(prev_valid_r && (prev_r == b_class));
    add  = emit && (cnt_r < CNT_W'(MAX_STEPS));

    if (b_score < 0) begin
      clamped = '0;
    end else if (b_score > SCORE_W'(SCORE_ONE)) begin
      clamped = CONF_W'(SCORE_ONE);
    end else begin
      clamped = b_score[CONF_W-1:0];
    end

    sum_upd  = sum_r + (add ? SUM_W'(clamped) : '0);
    cnt_upd  = cnt_r + CNT_W'(add);
    idx_full = CW'(b_class) - 1'b1;

    push_label = cmd.step && endstep && emit;
    div_start  = cmd.step && endstep && in_last_step;
    div_num    = NUM_W'({sum_upd, 1'b0}) + NUM_W'(cnt_upd);
    div_den    = {cnt_upd, 1'b0};

    pos_nxt        = pos_r;
    best_nxt       = best_r;
    bclass_nxt     = bclass_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    zero_nxt       = zero_r;

    if (cmd.step) begin
      best_nxt   = b_score;
      bclass_nxt = b_class;
      if (!endstep) begin
        pos_nxt = pos_r + 1'b1;
      end else if (in_last_step) begin
        pos_nxt        = '0;
        best_nxt       = '0;
        bclass_nxt     = '0;
        prev_nxt       = '0;
        prev_valid_nxt = 1'b0;
        sum_nxt        = '0;
        cnt_nxt        = '0;
        zero_nxt       = cnt_upd == '0;
      end else begin
        pos_nxt = '0;
        sum_nxt = sum_upd;
        cnt_nxt = cnt_upd;
        if (b_class == '0) begin
          prev_valid_nxt = 1'b0;
        end else begin
          prev_nxt       = b_class;
          prev_valid_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      best_r       <= '0;
      bclass_r     <= '0;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      sum_r        <= '0;
      cnt_r        <= '0;
      zero_r       <= 1'b1;
    end else begin
      pos_r        <= pos_nxt;
      best_r       <= best_nxt;
      bclass_r     <= bclass_nxt;
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      zero_r       <= zero_nxt;
    end
  end

  ctc_gd_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (div_quo)
  );

  // The mean never exceeds 1.0, so the low quotient bits hold it whole.
  assign conf_val = zero_r ? '0 : div_quo[CONF_W-1:0];

  // Two-entry result queue: slot0 is the head.
  always_comb begin
    push = push_label || cmd.push_conf;
    if (cmd.push_conf) begin
      push_data.kind       = KIND_CONF;
      push_data.dict_index = '0;
      push_data.confidence = conf_val;
      push_data.last       = 1'b1;
    end else begin
      push_data.kind       = KIND_LABEL;
      push_data.dict_index = idx_full[IDX_W-1:0];
      push_data.confidence = '0;
      push_data.last       = 1'b0;
    end

    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    fcnt_nxt  = fcnt_r;
    case ({push, out_pop})
      2'b11: begin
        if (fcnt_r == 2'd1) begin
          slot0_nxt = push_data;
        end else begin
          slot0_nxt = slot1_r;
          slot1_nxt = push_data;
        end
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        fcnt_nxt  = fcnt_r - 2'd1;
      end
      2'b10: begin
        if (fcnt_r == 2'd0) begin
          slot0_nxt = push_data;
        end else begin
          slot1_nxt = push_data;
        end
        fcnt_nxt = fcnt_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
    end else begin
      fcnt_r <= fcnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid        = fcnt_r != 2'd0;
  assign out_result       = slot0_r;
  assign status.fifo_free = fcnt_r != 2'd2;
  assign status.seq_end   = endstep && in_last_step;
  assign status.div_busy  = div_busy;

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= 2'd2) else $error("result queue count out of range");

  a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> fcnt_r != 2'd2) else $error("score taken with full result queue");

  a_step_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !div_busy) else $error("score taken during divide");

  a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_conf |-> (conf_val <= CONF_W'(SCORE_ONE) && !div_busy))
    else $error("confidence pushed out of range or early");

endmodule

### hdl/ctc_gd_ctrl.sv
module ctc_gd_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  ctc_gd_pkg::ctc_gd_status_t status,
  output ctc_gd_pkg::ctc_gd_cmd_t    cmd
);

  import ctc_gd_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.step      = 1'b0;
    cmd.push_conf = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_tready = status.fifo_free;
        if (in_tvalid && status.fifo_free) begin
          cmd.step = 1'b1;
          if (status.seq_end) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (status.fifo_free) begin
          cmd.push_conf = 1'b1;
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

endmodule
